/* rtl/jsu_pkg.sv */
package jsu_pkg;

    // result status codes
    localparam logic [1:0] ST_UNIT  = 2'd0;
    localparam logic [1:0] ST_QUOTE = 2'd1;
    localparam logic [1:0] ST_EOT   = 2'd2;
    localparam logic [1:0] ST_NOSTR = 2'd3;

    localparam logic [15:0] UNIT_QMARK = 16'h003F;
    localparam logic [15:0] CAP_RESET  = 16'd900;

    // one feed step: some '?' units followed by an optional unit or status
    typedef struct packed {
        logic [1:0]  n_qmark;
        logic        has_tail;
        logic        tail_is_status;
        logic [1:0]  tail_status;
        logic [15:0] tail_unit;
        logic        last;
    } grp_t;

endpackage

/* rtl/json_string_utf8_decoder.sv */
// path: each result of a byte passes through the queue, then the output register
// throughput: one byte per cycle while each byte gives at most one result and the output
// is not stalled; a byte with several results (malformed utf-8) leaves one result at a time,
// and end of text inside \u replays each held digit, then the end of text, before new input
// reset: rst_n async active low; clears the parser, queue and output valid, capacity to 900
module json_string_utf8_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // unit_capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // text_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // status[1:0], code_unit[17:2], zero pad[23:18]
    output logic        m_tlast         // last_of_run
);

    logic [15:0]   cap_reg;
    logic          q_full;
    logic          push;
    jsu_pkg::grp_t push_grp;
    logic          pop;
    logic          head_valid;
    jsu_pkg::grp_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= jsu_pkg::CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    jsu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cap      (cap_reg),
        .q_full   (q_full),
        .push     (push),
        .push_grp (push_grp)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_grp   (push_grp),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* rtl/jsu_front.sv */
module jsu_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic [15:0]      cap,
    input  logic             q_full,
    output logic             push,
    output jsu_pkg::grp_t    push_grp
);

    typedef enum logic [6:0] {
        M_SEEK   = 7'b0000001,
        M_BODY   = 7'b0000010,
        M_ESC    = 7'b0000100,
        M_HEX    = 7'b0001000,
        M_WAIT2  = 7'b0010000,
        M_WAIT3A = 7'b0100000,
        M_WAIT3B = 7'b1000000
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h37);
        return v;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [7:0]  lead_reg, lead_next;
    logic [7:0]  second_reg, second_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  held_reg [3];
    logic        held_we;
    logic [15:0] ue_reg, ue_next;
    logic        rp_active_reg, rp_active_next;
    logic [1:0]  rp_left_reg, rp_left_next;
    logic [7:0]  rp_bytes_reg [3];
    logic [7:0]  rp_bytes_next [3];

    logic        feed;
    logic [7:0]  b;
    logic        is_cont;
    logic        do_body;
    logic        fin;
    logic        seek_clr;
    logic        rp_start;
    logic [1:0]  nq;
    logic        tail_unit_v;
    logic [15:0] tail_unit;
    logic [1:0]  fin_status;
    logic [15:0] acc_new;
    logic [16:0] ue_ext, cap_ext;
    logic        ok1, ok2, ok3;
    logic [1:0]  keep_q;
    logic        keep_tail;

    always_comb
    begin
        feed     = !q_full && (rp_active_reg || s_tvalid);
        s_tready = !q_full && !rp_active_reg;
        if (rp_active_reg)
            b = (rp_left_reg != 2'd0) ? rp_bytes_reg[0] : 8'h00;
        else
            b = s_tdata;
        is_cont = (b[7:6] == 2'b10);

        mode_next   = mode_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        held_we     = 1'b0;
        do_body     = 1'b0;
        fin         = 1'b0;
        seek_clr    = 1'b0;
        rp_start    = 1'b0;
        nq          = 2'd0;
        tail_unit_v = 1'b0;
        tail_unit   = 16'h0000;
        fin_status  = jsu_pkg::ST_EOT;
        acc_new     = {acc_reg[11:0], hex_val(b)};

        unique case (mode_reg)
            M_SEEK:
            begin
                if (b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB)
                begin
                    mode_next = M_SEEK;
                end
                else if (b == CH_QUOTE)
                begin
                    mode_next = M_BODY;
                    seek_clr  = 1'b1;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = jsu_pkg::ST_NOSTR;
                end
            end
            M_BODY:
            begin
                do_body = 1'b1;
            end
            M_WAIT2:
            begin
                if (is_cont)
                begin
                    tail_unit_v = 1'b1;
                    tail_unit   = {5'd0, lead_reg[4:0], b[5:0]};
                    mode_next   = M_BODY;
                end
                else
                begin
                    nq      = 2'd1;
                    do_body = 1'b1;
                end
            end
            M_WAIT3A:
            begin
                if (is_cont)
                begin
                    second_next = b;
                    mode_next   = M_WAIT3B;
                end
                else
                begin
                    nq      = 2'd1;
                    do_body = 1'b1;
                end
            end
            M_WAIT3B:
            begin
                if (is_cont)
                begin
                    tail_unit_v = 1'b1;
                    tail_unit   = {lead_reg[3:0], second_reg[5:0], b[5:0]};
                    mode_next   = M_BODY;
                end
                else
                begin
                    nq      = 2'd2;
                    do_body = 1'b1;
                end
            end
            M_ESC:
            begin
                mode_next = M_BODY;
                if (b == 8'h00)
                begin
                    fin        = 1'b1;
                    fin_status = jsu_pkg::ST_EOT;
                end
                else if (b == CH_U)
                begin
                    mode_next = M_HEX;
                    cnt_next  = 2'd0;
                    acc_next  = 16'h0000;
                end
                else if (b == CH_N)
                begin
                    tail_unit_v = 1'b1;
                    tail_unit   = 16'h000A;
                end
                else if (b == CH_T)
                begin
                    tail_unit_v = 1'b1;
                    tail_unit   = {8'h00, CH_SPACE};
                end
                else
                begin
                    tail_unit_v = 1'b1;
                    tail_unit   = {8'h00, b};
                end
            end
            M_HEX:
            begin
                if (b == 8'h00)
                begin
                    // emit 'u' and replay the held digits, then the end of text
                    tail_unit_v = 1'b1;
                    tail_unit   = {8'h00, CH_U};
                    cnt_next    = 2'd0;
                    mode_next   = M_BODY;
                    rp_start    = 1'b1;
                end
                else
                begin
                    acc_next = acc_new;
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next    = 2'd0;
                        mode_next   = M_BODY;
                        tail_unit_v = 1'b1;
                        tail_unit   = acc_new;
                    end
                    else
                    begin
                        held_we  = 1'b1;
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                mode_next = M_SEEK;
            end
        endcase

        if (do_body)
        begin
            mode_next = M_BODY;
            if (b == 8'h00)
            begin
                fin        = 1'b1;
                fin_status = jsu_pkg::ST_EOT;
            end
            else if (b == CH_QUOTE)
            begin
                fin        = 1'b1;
                fin_status = jsu_pkg::ST_QUOTE;
            end
            else if (b == CH_BSL)
            begin
                mode_next = M_ESC;
            end
            else if (!b[7])
            begin
                tail_unit_v = 1'b1;
                tail_unit   = {8'h00, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                lead_next = b;
                mode_next = M_WAIT2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                lead_next = b;
                mode_next = M_WAIT3A;
            end
            else
            begin
                tail_unit_v = 1'b1;
                tail_unit   = jsu_pkg::UNIT_QMARK;
            end
        end

        if (fin)
        begin
            mode_next = M_SEEK;
            cnt_next  = 2'd0;
        end

        // units past capacity minus one are dropped, in order
        ue_ext  = {1'b0, ue_reg};
        cap_ext = {1'b0, cap};
        ok1     = (ue_ext + 17'd1) < cap_ext;
        ok2     = (ue_ext + 17'd2) < cap_ext;
        ok3     = (ue_ext + 17'd3) < cap_ext;
        case (nq)
            2'd0:
            begin
                keep_q    = 2'd0;
                keep_tail = tail_unit_v && ok1;
            end
            2'd1:
            begin
                keep_q    = ok1 ? 2'd1 : 2'd0;
                keep_tail = tail_unit_v && ok2;
            end
            default:
            begin
                keep_q    = ok2 ? 2'd2 : (ok1 ? 2'd1 : 2'd0);
                keep_tail = tail_unit_v && ok3;
            end
        endcase

        if (fin || seek_clr)
            ue_next = 16'h0000;
        else
            ue_next = ue_reg + {14'd0, keep_q} + {15'd0, keep_tail};

        push_grp.n_qmark        = keep_q;
        push_grp.has_tail       = fin || keep_tail;
        push_grp.tail_is_status = fin;
        push_grp.tail_status    = fin ? fin_status : jsu_pkg::ST_UNIT;
        push_grp.tail_unit      = fin ? 16'h0000 : tail_unit;
        push_grp.last           = !rp_start && (!rp_active_reg || fin);
        push = feed && ((keep_q != 2'd0) || fin || keep_tail);

        rp_active_next   = rp_active_reg;
        rp_left_next     = rp_left_reg;
        rp_bytes_next[0] = rp_bytes_reg[0];
        rp_bytes_next[1] = rp_bytes_reg[1];
        rp_bytes_next[2] = rp_bytes_reg[2];
        if (rp_start)
        begin
            rp_active_next   = 1'b1;
            rp_left_next     = cnt_reg;
            rp_bytes_next[0] = held_reg[0];
            rp_bytes_next[1] = held_reg[1];
            rp_bytes_next[2] = held_reg[2];
        end
        else if (rp_active_reg)
        begin
            if (fin)
            begin
                rp_active_next = 1'b0;
            end
            else if (rp_left_reg != 2'd0)
            begin
                rp_left_next     = rp_left_reg - 2'd1;
                rp_bytes_next[0] = rp_bytes_reg[1];
                rp_bytes_next[1] = rp_bytes_reg[2];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_SEEK;
            lead_reg      <= 8'h00;
            second_reg    <= 8'h00;
            acc_reg       <= 16'h0000;
            cnt_reg       <= 2'd0;
            ue_reg        <= 16'h0000;
            rp_active_reg <= 1'b0;
            rp_left_reg   <= 2'd0;
        end
        else if (feed)
        begin
            mode_reg      <= mode_next;
            lead_reg      <= lead_next;
            second_reg    <= second_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            ue_reg        <= ue_next;
            rp_active_reg <= rp_active_next;
            rp_left_reg   <= rp_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed)
        begin
            if (held_we)
                held_reg[cnt_reg] <= b;
            rp_bytes_reg[0] <= rp_bytes_next[0];
            rp_bytes_reg[1] <= rp_bytes_next[1];
            rp_bytes_reg[2] <= rp_bytes_next[2];
        end
    end

endmodule

/* rtl/jsu_queue.sv */
module jsu_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jsu_pkg::grp_t    push_grp,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output jsu_pkg::grp_t    head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::grp_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    always_comb
    begin
        full       = (count_reg == CW'(DEPTH));
        head_valid = (count_reg != '0);
        head       = mem_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_grp;
    end

endmodule

/* rtl/jsu_back.sv */
module jsu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  jsu_pkg::grp_t    head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    logic [1:0]  idx_reg;
    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] unit_reg;
    logic        last_reg;

    logic        load;
    logic [1:0]  total;
    logic        final_item;
    logic [1:0]  item_status;
    logic [15:0] item_unit;

    always_comb
    begin
        load       = head_valid && (!valid_reg || m_tready);
        total      = head.n_qmark + {1'b0, head.has_tail};
        final_item = (idx_reg == total - 2'd1);
        pop        = load && final_item;
        if (idx_reg < head.n_qmark)
        begin
            item_status = jsu_pkg::ST_UNIT;
            item_unit   = jsu_pkg::UNIT_QMARK;
        end
        else
        begin
            item_status = head.tail_status;
            item_unit   = head.tail_unit;
        end
        m_tvalid = valid_reg;
        m_tdata  = {6'd0, unit_reg, status_reg};
        m_tlast  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_item ? 2'd0 : idx_reg + 2'd1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= item_status;
            unit_reg   <= item_unit;
            last_reg   <= final_item && head.last;
        end
    end

endmodule

/* rtl/jsu_checker.sv */
module jsu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a string end or not-a-string word carries no code unit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != 2'd0) |-> (m_tdata[17:2] == 16'h0000))
        else $error("status word with nonzero code unit");

    // a status word is always the final result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != 2'd0) |-> m_tlast)
        else $error("status word not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:18] == 6'd0))
        else $error("pad bits set in output word");

endmodule

bind json_string_utf8_decoder jsu_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
